// ----- hw/rtl/jfp_pkg.sv -----
package jfp_pkg;

  localparam int FRAME_BYTES        = 8;
  localparam int BUTTON_FRAME_BYTES = 3;
  localparam int POS_W              = $clog2(FRAME_BYTES + 1);

  localparam int ASCII_ZERO   = 48;
  localparam int STICK_OFFSET = 200;
  localparam int STICK_LIMIT  = 100;
  // (a-48)*100 + (b-48)*10 + (c-48) - 200 == a*100 + b*10 + c - DIGIT_BIAS
  localparam int DIGIT_BIAS   = ASCII_ZERO * 111 + STICK_OFFSET;

  localparam logic [7:0] LETTER_FIRST = 8'h41;  // 'A'
  localparam logic [7:0] LETTER_LAST  = 8'h4C;  // 'L'

  // register index taken from paddr[2]
  localparam logic REG_START_CODE = 1'b0;
  localparam logic REG_END_CODE   = 1'b1;

  localparam logic [7:0] START_CODE_RST = 8'h02;
  localparam logic [7:0] END_CODE_RST   = 8'h03;

endpackage

// ----- hw/rtl/jfp_digits3.sv -----
module jfp_digits3 (
  input  logic [7:0]        hundreds,
  input  logic [7:0]        tens,
  input  logic [7:0]        ones,
  output logic signed [7:0] value,
  output logic              in_range
);

  logic [14:0]        sum;
  logic signed [15:0] diff;

  // max 255*111 = 28305, fits 15 bits
  assign sum  = 15'(hundreds) * 15'd100 + 15'(tens) * 15'd10 + 15'(ones);
  assign diff = signed'({1'b0, sum}) - 16'(jfp_pkg::DIGIT_BIAS);

  assign in_range = (diff >= -16'(jfp_pkg::STICK_LIMIT)) &&
                    (diff <= 16'(jfp_pkg::STICK_LIMIT));
  assign value    = diff[7:0];

endmodule

// ----- hw/rtl/joystick_frame_parser.sv -----
// An accepted input item passes the input register, then parse logic into the result
// register. Throughput: one item per cycle while the result channel is not stalled;
// the result register frees as it is taken.
// Reset (rst, synchronous): pipeline empty, frame position, buttons and stick values
// cleared, start_code = 0x02, end_code = 0x03.
module joystick_frame_parser (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        frame_len,
  output logic signed [7:0] joy_x,
  output logic signed [7:0] joy_y,
  output logic [5:0]        buttons,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PW = jfp_pkg::POS_W;

  logic [7:0] start_code;
  logic [7:0] end_code;

  logic       in_full;
  logic [7:0] byte_q;
  logic       advance;

  logic [PW-1:0]     frame_pos;
  logic [PW-1:0]     frame_pos_next;
  logic [7:0]        frame_buf [1:jfp_pkg::FRAME_BYTES-2];
  logic              buf_wr;
  logic [5:0]        button_bits;
  logic [5:0]        button_bits_next;
  logic signed [7:0] stick_x;
  logic signed [7:0] stick_x_next;
  logic signed [7:0] stick_y;
  logic signed [7:0] stick_y_next;
  logic [2:0]        len_next;

  logic signed [7:0] dec_x;
  logic signed [7:0] dec_y;
  logic              x_ok;
  logic              y_ok;

  // ---- configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == jfp_pkg::REG_END_CODE) ? {24'd0, end_code}
                                                      : {24'd0, start_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= jfp_pkg::START_CODE_RST;
      end_code   <= jfp_pkg::END_CODE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        jfp_pkg::REG_START_CODE: start_code <= pwdata[7:0];
        jfp_pkg::REG_END_CODE:   end_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---- handshake
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

  // ---- stick decode from the held number bytes
  jfp_digits3 u_dec_x (
    .hundreds (frame_buf[1]),
    .tens     (frame_buf[2]),
    .ones     (frame_buf[3]),
    .value    (dec_x),
    .in_range (x_ok)
  );

  jfp_digits3 u_dec_y (
    .hundreds (frame_buf[4]),
    .tens     (frame_buf[5]),
    .ones     (frame_buf[6]),
    .value    (dec_y),
    .in_range (y_ok)
  );

  // ---- parse step
  always_comb begin
    logic [7:0] idx;
    logic [2:0] bit_sel;
    frame_pos_next   = frame_pos;
    button_bits_next = button_bits;
    stick_x_next     = stick_x;
    stick_y_next     = stick_y;
    len_next         = 3'd0;
    buf_wr           = 1'b0;
    idx              = frame_buf[1] - jfp_pkg::LETTER_FIRST;
    bit_sel          = idx[3:1];

    if (frame_pos == '0 && byte_q == start_code) begin
      frame_pos_next = PW'(1);
    end else if (frame_pos != '0 && frame_pos < PW'(jfp_pkg::FRAME_BYTES)) begin
      buf_wr         = (frame_pos <= PW'(jfp_pkg::FRAME_BYTES - 2));
      frame_pos_next = frame_pos + PW'(1);
      if (byte_q == end_code) begin
        // frame closes; length minus one equals the old position
        len_next       = frame_pos[2:0];
        frame_pos_next = '0;
        if (frame_pos == PW'(jfp_pkg::BUTTON_FRAME_BYTES - 1)) begin
          if (frame_buf[1] >= jfp_pkg::LETTER_FIRST &&
              frame_buf[1] <= jfp_pkg::LETTER_LAST) begin
            if (!idx[0]) begin
              button_bits_next = button_bits | (6'd1 << bit_sel);
            end else begin
              button_bits_next = button_bits & ~(6'd1 << bit_sel);
            end
          end
        end else if (frame_pos == PW'(jfp_pkg::FRAME_BYTES - 1)) begin
          if (x_ok && y_ok) begin
            stick_x_next = dec_x;
            stick_y_next = dec_y;
          end
        end
      end
    end else begin
      // idle non-start byte or overflow byte
      frame_pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos   <= '0;
      button_bits <= '0;
      stick_x     <= '0;
      stick_y     <= '0;
    end else if (advance) begin
      frame_pos   <= frame_pos_next;
      button_bits <= button_bits_next;
      stick_x     <= stick_x_next;
      stick_y     <= stick_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && buf_wr) begin
      frame_buf[frame_pos[2:0]] <= byte_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      frame_len <= len_next;
      joy_x     <= stick_x_next;
      joy_y     <= stick_y_next;
      buttons   <= button_bits_next;
    end
  end

endmodule
